FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the text blitter RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define GTRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every rising clock edge outside reset
`define GTRB_ASSERT_IMP(lbl, ante, cons, msg) \
  `GTRB_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: sv/gtrb_pkg.sv
// ---------------------------------------------------------------------------
// gtrb_pkg
// Types, constants and the 5x7 font table for the glyph text blitter.
// ---------------------------------------------------------------------------
package gtrb_pkg;

  localparam int FontRows = 7;
  localparam int FontCols = 5;
  localparam int NumGlyphs = 39;

  // Largest clipping extent; larger register values saturate to this
  localparam logic [10:0] FrameLimit = 11'd1024;

  // Configuration register indexes
  localparam logic RegFrameWidth  = 1'b0;
  localparam logic RegFrameHeight = 1'b1;

  // Glyph indexes for the special characters
  localparam logic [5:0] GlyphBlank = 6'd0;
  localparam logic [5:0] GlyphFirstLetter = 6'd1;
  localparam logic [5:0] GlyphFirstDigit = 6'd27;
  localparam logic [5:0] GlyphDash = 6'd37;
  localparam logic [5:0] GlyphDot = 6'd38;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  // One character as latched at the input transfer
  typedef struct packed {
    logic signed [15:0] base_x;
    logic signed [11:0] pen_y;
    logic [3:0]         scale;
    logic [7:0]         ink;
    logic [5:0]         glyph;
  } item_t;

  // One clipped square
  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic [3:0] w;
    logic [3:0] h;
  } rect_t;

  // Clip unit result
  typedef struct packed {
    logic  visible;
    rect_t rect;
  } clip_t;

  // Font bitmap, leftmost column in bit 4
  localparam logic [4:0] Glyphs [NumGlyphs][FontRows] = '{
    '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
    '{5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
    '{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
    '{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14},
    '{5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    '{5'd14, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14},
    '{5'd1, 5'd1, 5'd1, 5'd1, 5'd17, 5'd17, 5'd14},
    '{5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
    '{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
    '{5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
    '{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
    '{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
    '{5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
    '{5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30},
    '{5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
    '{5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
    '{5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17},
    '{5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4},
    '{5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31},
    '{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
    '{5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14},
    '{5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31},
    '{5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30},
    '{5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30},
    '{5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
    '{5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8},
    '{5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
    '{5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd1, 5'd14},
    '{5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12, 5'd12}
  };

  // Character code to glyph index; unknown codes give the blank glyph
  function automatic logic [5:0] glyph_of(logic [7:0] ch);
    logic [5:0] g;
    g = GlyphBlank;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      g = GlyphFirstLetter + 6'(ch - 8'h41);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      g = GlyphFirstDigit + 6'(ch - 8'h30);
    end else if (ch == 8'h2D) begin
      g = GlyphDash;
    end else if (ch == 8'h2E) begin
      g = GlyphDot;
    end
    return g;
  endfunction

  // One font row; out-of-range codes read as blank
  function automatic logic [4:0] glyph_row(logic [5:0] g, logic [2:0] r);
    logic [4:0] bits;
    bits = '0;
    if (g < 6'(NumGlyphs) && r < 3'(FontRows)) begin
      bits = Glyphs[g][r];
    end
    return bits;
  endfunction

endpackage

FILE: sv/glyph_text_rect_blitter.sv
// ---------------------------------------------------------------------------
// glyph_text_rect_blitter
// 5x7 font text blitter: turns one character into clipped filled squares.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream: one character per transfer with pen position, scale and
//   ink; tuser set starts a new string at pen_x, otherwise the kept cursor
//   is used. The cursor advances by 6 * scale on every character.
//   Output stream: one clipped square per visible font dot, row by row, left
//   to right; tlast marks the final square. No visible dot, no transfer.
//   Throughput: one font bit per cycle through a single clip unit while the
//   output is not stalled; a character is scanned and then flushed, with
//   tready low from the transfer until it is done. Scale 0 skips the scan,
//   so tready stays high.
//   Latency: a square is held back until the next visible dot or the flush,
//   then enters the output register; a stall halts the scan on the next
//   visible dot with one square waiting and one held back.
//   Reset: frame 320 x 288, cursor 0, output empty.
// ---------------------------------------------------------------------------
module glyph_text_rect_blitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_wdata_i,
  // Character stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // char_code[7:0], pen_x[19:8], pen_y[31:20], glyph_scale[35:32], ink[43:36]
  input  logic [47:0] s_axis_tdata,
  // start_string[0]
  input  logic        s_axis_tuser,
  // Square stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // rect_x[9:0], rect_y[19:10], rect_width[23:20], rect_height[27:24],
  // rect_color[35:28]
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic [10:0]        frame_w_q;
  logic [10:0]        frame_h_q;
  logic [10:0]        frame_w;
  logic [10:0]        frame_h;
  logic signed [15:0] cursor_q, cursor_d;
  logic signed [15:0] base_x;
  logic [3:0]         scale;
  logic [15:0]        advance;
  logic               accept;
  gtrb_pkg::item_t    item;
  gtrb_pkg::rect_t    out_rect;
  logic [7:0]         out_color;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Frame registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q <= 11'd320;
      frame_h_q <= 11'd288;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gtrb_pkg::RegFrameWidth:  frame_w_q <= cfg_wdata_i;
        gtrb_pkg::RegFrameHeight: frame_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clip extents saturate at the frame limit
  assign frame_w = (frame_w_q > gtrb_pkg::FrameLimit) ? gtrb_pkg::FrameLimit : frame_w_q;
  assign frame_h = (frame_h_q > gtrb_pkg::FrameLimit) ? gtrb_pkg::FrameLimit : frame_h_q;

  // Character left edge and cursor advance of 6 * scale
  assign scale    = s_axis_tdata[35:32];
  assign base_x   = s_axis_tuser ? 16'($signed(s_axis_tdata[19:8])) : cursor_q;
  assign advance  = {11'b0, scale, 1'b0} + {10'b0, scale, 2'b0};
  assign cursor_d = base_x + $signed(advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else if (accept) begin
      cursor_q <= cursor_d;
    end
  end

  // Item handed to the sequencer
  assign item.base_x = base_x;
  assign item.pen_y  = $signed(s_axis_tdata[31:20]);
  assign item.scale  = scale;
  assign item.ink    = s_axis_tdata[43:36];
  assign item.glyph  = gtrb_pkg::glyph_of(s_axis_tdata[7:0]);

  gtrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .item_i      (item),
    .frame_w_i   (frame_w),
    .frame_h_i   (frame_h),
    .ready_o     (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rect_o  (out_rect),
    .out_color_o (out_color),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, out_color, out_rect.h, out_rect.w, out_rect.y, out_rect.x};

endmodule

FILE: sv/gtrb_clip.sv
// ---------------------------------------------------------------------------
// gtrb_clip
// Shared clip unit: trims one scale x scale square to the frame and flags
// squares that lie wholly outside.
// ---------------------------------------------------------------------------
module gtrb_clip (
  input  logic signed [17:0] x_i,
  input  logic signed [13:0] y_i,
  input  logic [3:0]         scale_i,
  input  logic [10:0]        frame_w_i,
  input  logic [10:0]        frame_h_i,
  output gtrb_pkg::clip_t    clip_o
);

  logic signed [17:0] x1;
  logic signed [13:0] y1;
  logic signed [17:0] w_s;
  logic signed [13:0] h_s;
  logic signed [17:0] cx0;
  logic signed [17:0] cx1;
  logic signed [13:0] cy0;
  logic signed [13:0] cy1;
  logic signed [17:0] dx;
  logic signed [13:0] dy;

  // Far edges and frame extents as signed values
  assign x1  = x_i + $signed({14'b0, scale_i});
  assign y1  = y_i + $signed({10'b0, scale_i});
  assign w_s = $signed({7'b0, frame_w_i});
  assign h_s = $signed({3'b0, frame_h_i});

  // Clamp both edges into the frame
  assign cx0 = (x_i < 18'sd0) ? 18'sd0 : x_i;
  assign cy0 = (y_i < 14'sd0) ? 14'sd0 : y_i;
  assign cx1 = (x1 > w_s) ? w_s : x1;
  assign cy1 = (y1 > h_s) ? h_s : y1;
  assign dx  = cx1 - cx0;
  assign dy  = cy1 - cy0;

  assign clip_o.visible = (x1 > 18'sd0) && (y1 > 14'sd0) && (x_i < w_s) && (y_i < h_s);
  assign clip_o.rect.x  = cx0[9:0];
  assign clip_o.rect.y  = cy0[9:0];
  assign clip_o.rect.w  = dx[3:0];
  assign clip_o.rect.h  = dy[3:0];

endmodule

FILE: sv/gtrb_ctrl.sv
// ---------------------------------------------------------------------------
// gtrb_ctrl
// Glyph scan sequencer: walks the 35 font bits of one character through the
// shared clip unit, holds one square back to mark the last one, and feeds
// the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gtrb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  gtrb_pkg::item_t item_i,
  input  logic [10:0]     frame_w_i,
  input  logic [10:0]     frame_h_i,
  output logic            ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output gtrb_pkg::rect_t out_rect_o,
  output logic [7:0]      out_color_o,
  output logic            out_last_o
);

  gtrb_pkg::state_e state_q, state_d;

  gtrb_pkg::item_t    item_q;
  logic signed [17:0] base_x_q;
  logic signed [17:0] col_x_q;
  logic signed [13:0] row_y_q;
  logic [2:0]         col_q;
  logic [2:0]         row_q;

  gtrb_pkg::rect_t pend_q;
  logic            pend_valid_q, pend_valid_d;

  gtrb_pkg::rect_t out_rect_q;
  logic [7:0]      out_color_q;
  logic            out_last_q;
  logic            out_valid_q, out_valid_d;

  gtrb_pkg::clip_t clip;
  logic [4:0]      row_bits;
  logic [2:0]      bit_idx;
  logic            bit_set;
  logic            hit;
  logic            out_free;
  logic            end_of_row;
  logic            end_of_glyph;

  // Control strobes
  logic step;
  logic push;
  logic take;
  logic flush;

  // Shared clip unit
  gtrb_clip u_clip (
    .x_i       (col_x_q),
    .y_i       (row_y_q),
    .scale_i   (item_q.scale),
    .frame_w_i (frame_w_i),
    .frame_h_i (frame_h_i),
    .clip_o    (clip)
  );

  // Current font bit; leftmost column is the top bit of the row
  assign row_bits     = gtrb_pkg::glyph_row(item_q.glyph, row_q);
  assign bit_idx      = 3'(gtrb_pkg::FontCols - 1) - col_q;
  assign bit_set      = row_bits[bit_idx];
  assign hit          = (state_q == gtrb_pkg::ST_SCAN) && bit_set && clip.visible;
  assign out_free     = !out_valid_q || out_ready_i;
  assign end_of_row   = (col_q == 3'(gtrb_pkg::FontCols - 1));
  assign end_of_glyph = end_of_row && (row_q == 3'(gtrb_pkg::FontRows - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gtrb_pkg::ST_IDLE: begin
        if (start_i && (item_i.scale != 4'd0)) state_d = gtrb_pkg::ST_SCAN;
      end
      gtrb_pkg::ST_SCAN: begin
        if (step && end_of_glyph) state_d = gtrb_pkg::ST_FLUSH;
      end
      gtrb_pkg::ST_FLUSH: begin
        if (!pend_valid_q || out_free) state_d = gtrb_pkg::ST_IDLE;
      end
      default: state_d = gtrb_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    ready_o = 1'b0;
    step    = 1'b0;
    push    = 1'b0;
    take    = 1'b0;
    flush   = 1'b0;
    unique case (state_q)
      gtrb_pkg::ST_IDLE: begin
        ready_o = 1'b1;
      end
      gtrb_pkg::ST_SCAN: begin
        // a new square needs the held one moved out first
        step = !(hit && pend_valid_q && !out_free);
        push = hit && pend_valid_q && out_free;
        take = hit && step;
      end
      gtrb_pkg::ST_FLUSH: begin
        flush = pend_valid_q && out_free;
      end
      default: begin
        ready_o = 1'b0;
      end
    endcase
  end

  // Held square valid and output register valid
  always_comb begin
    pend_valid_d = pend_valid_q;
    if (take) begin
      pend_valid_d = 1'b1;
    end else if (flush) begin
      pend_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (push || flush) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gtrb_pkg::ST_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      col_q        <= '0;
      row_q        <= '0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (start_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (step) begin
        if (end_of_row) begin
          col_q <= '0;
          row_q <= row_q + 3'd1;
        end else begin
          col_q <= col_q + 3'd1;
        end
      end
    end
  end

  // Item and position registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      item_q   <= item_i;
      base_x_q <= 18'(item_i.base_x);
      col_x_q  <= 18'(item_i.base_x);
      row_y_q  <= 14'(item_i.pen_y);
    end else if (step) begin
      if (end_of_row) begin
        col_x_q <= base_x_q;
        row_y_q <= row_y_q + $signed({10'b0, item_q.scale});
      end else begin
        col_x_q <= col_x_q + $signed({14'b0, item_q.scale});
      end
    end
  end

  // Held square and output payload
  always_ff @(posedge clk_i) begin
    if (take) pend_q <= clip.rect;
    if (push || flush) begin
      out_rect_q  <= pend_q;
      out_color_q <= item_q.ink;
      out_last_q  <= flush;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rect_o  = out_rect_q;
  assign out_color_o = out_color_q;
  assign out_last_o  = out_last_q;

  // A new character never starts with a square still held back
  `GTRB_ASSERT_IMP(a_idle_empty, state_q == gtrb_pkg::ST_IDLE, !pend_valid_q,
                   "held square left over in idle")
  // Scan position stays inside the font cell
  `GTRB_ASSERT_IMP(a_scan_range, state_q == gtrb_pkg::ST_SCAN,
                   col_q < 3'(gtrb_pkg::FontCols) && row_q < 3'(gtrb_pkg::FontRows),
                   "scan position out of range")
  // A stalled output holds its square
  `GTRB_ASSERT_IMP(a_out_hold, out_valid_q && !out_ready_i, ##1 $stable(out_rect_q),
                   "stalled square changed")

endmodule

FILE: tb/gtrb_tb_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Text blitter scoreboard
// Font table, transfer types and the square predictor that tracks the pen
// cursor and frame size and checks every output transfer in order.
// ---------------------------------------------------------------------------
package gtrb_tb_pkg;
  import gtrb_pkg::*;

  localparam int FrameCap = 1024;

  // One character transfer, as the sender sees it
  typedef struct packed {
    logic [7:0]  code;
    logic        start;
    logic [11:0] pen_x;
    logic [11:0] pen_y;
    logic [3:0]  scale;
    logic [7:0]  ink;
  } glyph_req_t;

  // One drawn square, as the receiver sees it
  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic [3:0] w;
    logic [3:0] h;
    logic [7:0] color;
    logic       last;
  } square_t;

  // 5x7 font: blank, A-Z, 0-9, dash, dot; leftmost column in bit 4
  localparam logic [4:0] BlitFont [39][7] = '{
    '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
    '{5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
    '{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
    '{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14},
    '{5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    '{5'd14, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14},
    '{5'd1, 5'd1, 5'd1, 5'd1, 5'd17, 5'd17, 5'd14},
    '{5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
    '{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
    '{5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
    '{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
    '{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
    '{5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
    '{5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30},
    '{5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
    '{5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
    '{5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17},
    '{5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4},
    '{5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31},
    '{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
    '{5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14},
    '{5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31},
    '{5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30},
    '{5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30},
    '{5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
    '{5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8},
    '{5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
    '{5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd1, 5'd14},
    '{5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12, 5'd12}
  };

  class glyph_scoreboard;
    logic [10:0]        frame_w;
    logic [10:0]        frame_h;
    logic signed [15:0] cursor;
    square_t            squares[$];
    int                 errors;

    function new();
      frame_w = 11'd320;
      frame_h = 11'd288;
      cursor  = '0;
      errors  = 0;
    endfunction

    function int pending();
      return squares.size();
    endfunction

    function void set_frame(logic idx, logic [10:0] value);
      if (idx == RegFrameWidth) begin
        frame_w = value;
      end else begin
        frame_h = value;
      end
    endfunction

    // Character code to font entry; anything unlisted is blank
    function int font_index(logic [7:0] code);
      if (code >= 8'h41 && code <= 8'h5A) return 1 + int'(code) - 'h41;
      if (code >= 8'h30 && code <= 8'h39) return 27 + int'(code) - 'h30;
      if (code == 8'h2D) return 37;
      if (code == 8'h2E) return 38;
      return 0;
    endfunction

    // Accepted character: queue its visible squares, then move the cursor
    function void note_char(glyph_req_t req);
      int      fw, fh, bx, top, s, g, added;
      int      x0, y0, x1, y1;
      square_t sq;
      fw = (frame_w > FrameCap) ? FrameCap : int'(frame_w);
      fh = (frame_h > FrameCap) ? FrameCap : int'(frame_h);
      if (req.start) cursor = {{4{req.pen_x[11]}}, req.pen_x};
      bx    = cursor;
      top   = $signed(req.pen_y);
      s     = req.scale;
      g     = font_index(req.code);
      added = 0;
      for (int gy = 0; gy < FontRows; gy++) begin
        for (int gx = 0; gx < FontCols; gx++) begin
          if (s == 0 || !BlitFont[g][gy][FontCols - 1 - gx]) continue;
          x0 = bx + gx * s;
          y0 = top + gy * s;
          x1 = x0 + s;
          y1 = y0 + s;
          // fully outside the frame: no square at all
          if (x1 <= 0 || y1 <= 0 || x0 >= fw || y0 >= fh) continue;
          if (x0 < 0) x0 = 0;
          if (y0 < 0) y0 = 0;
          if (x1 > fw) x1 = fw;
          if (y1 > fh) y1 = fh;
          sq.x     = 10'(x0);
          sq.y     = 10'(y0);
          sq.w     = 4'(x1 - x0);
          sq.h     = 4'(y1 - y0);
          sq.color = req.ink;
          sq.last  = 1'b0;
          squares.push_back(sq);
          added++;
        end
      end
      if (added > 0) begin
        sq = squares[squares.size() - 1];
        sq.last = 1'b1;
        squares[squares.size() - 1] = sq;
      end
      // 16-bit two's complement wrap
      cursor = cursor + 16'(6 * s);
    endfunction

    function void compare(string name, int want_v, int got_v);
      if (want_v != got_v) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
        errors++;
      end
    endfunction

    // Output transfer: compare with the oldest pending square
    function void check_square(logic [39:0] data, logic last);
      square_t want;
      if (squares.size() == 0) begin
        $display("%0t: square expected none, got x=%0d y=%0d w=%0d h=%0d last=%0b",
                 $time, data[9:0], data[19:10], data[23:20], data[27:24], last);
        errors++;
        return;
      end
      want = squares.pop_front();
      compare("rect_x", want.x, data[9:0]);
      compare("rect_y", want.y, data[19:10]);
      compare("rect_width", want.w, data[23:20]);
      compare("rect_height", want.h, data[27:24]);
      compare("rect_color", want.color, data[35:28]);
      compare("last_of_char", want.last, last);
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives characters into the text blitter under several frame sizes, with
// random gaps and stalls on both streams, and checks every square against
// the scoreboard's prediction.
// ---------------------------------------------------------------------------
module tb_top;
  import gtrb_pkg::*;
  import gtrb_tb_pkg::*;

  localparam int CycleLimit  = 500000;
  localparam int SettleCyc   = 60;
  localparam int HoldCycles  = 400;
  localparam int IdlePercent = 14;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [10:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // char_code, pen_x, pen_y, glyph_scale, ink (lowest bit first)
  logic [47:0] s_axis_tdata;
  // start_string
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // rect_x, rect_y, rect_width, rect_height, rect_color (lowest bit first)
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  glyph_scoreboard sb;
  bit              steady_flow;
  bit              hold_req;
  int              cycle_cnt;

  glyph_text_rect_blitter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("glyph_text_rect_blitter: mismatch");
    $finish;
  end

  // Square receiver: random stalls, one long hold-off on request
  initial begin : square_sink
    int hold_cnt;
    hold_cnt = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        sb.check_square(m_axis_tdata, m_axis_tlast);
      end
      if (hold_req && hold_cnt < HoldCycles) begin
        hold_cnt++;
        m_axis_tready <= 1'b0;
      end else begin
        if (hold_req) begin
          hold_req = 1'b0;
          hold_cnt = 0;
        end
        m_axis_tready <= steady_flow || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  function automatic glyph_req_t make_req(logic [7:0] code, bit start, int px, int py,
                                          int scale, logic [7:0] ink);
    glyph_req_t req;
    req.code  = code;
    req.start = start;
    req.pen_x = 12'(px);
    req.pen_y = 12'(py);
    req.scale = 4'(scale);
    req.ink   = ink;
    return req;
  endfunction

  // Random character, mostly placed near the frame of size w x h
  function automatic glyph_req_t random_char(bit start, int w, int h);
    int         pick, fw, fh, px, py, scale;
    logic [7:0] code;
    fw   = (w > FrameCap) ? FrameCap : w;
    fh   = (h > FrameCap) ? FrameCap : h;
    pick = $urandom_range(99);
    if (pick < 55) code = 8'(8'h41 + $urandom_range(25));
    else if (pick < 75) code = 8'(8'h30 + $urandom_range(9));
    else if (pick < 80) code = 8'h2D;
    else if (pick < 85) code = 8'h2E;
    else if (pick < 88) code = 8'h20;
    else code = 8'($urandom_range(255));
    px = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(fw + 48) - 40;
    py = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(fh + 48) - 40;
    pick = $urandom_range(99);
    if (pick < 4) scale = 0;
    else if (pick < 60) scale = $urandom_range(1, 3);
    else scale = $urandom_range(1, 15);
    return make_req(code, start, px, py, scale, 8'($urandom_range(255)));
  endfunction

  // One character transfer; tvalid stays high afterwards until the next
  // call or a drain lowers it
  task automatic send_char(glyph_req_t req);
    if (!steady_flow && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, req.ink, req.scale, req.pen_y, req.pen_x, req.code};
    s_axis_tuser  <= req.start;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_char(req);
  endtask

  // Wait until every square has arrived and the last character is done
  task automatic drain_blitter();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_frame(int w, int h);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegFrameWidth;
    cfg_wdata_i <= 11'(w);
    @(posedge clk_i);
    sb.set_frame(RegFrameWidth, 11'(w));
    cfg_idx_i   <= RegFrameHeight;
    cfg_wdata_i <= 11'(h);
    @(posedge clk_i);
    sb.set_frame(RegFrameHeight, 11'(h));
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Strings of random length under one frame size; a few runs continue
  // from the previous cursor instead of starting fresh
  task automatic run_phase(int w, int h, int items);
    int left, run_len;
    drain_blitter();
    write_frame(w, h);
    left = items;
    while (left > 0) begin
      run_len = $urandom_range(1, 8);
      for (int i = 0; i < run_len && left > 0; i++) begin
        send_char(random_char(i == 0 && $urandom_range(9) != 0, w, h));
        left--;
      end
    end
  endtask

  task automatic run_directed();
    // every glyph class, field extremes, unknown codes
    send_char(make_req(8'h41, 1, 10, 20, 1, 8'h00));
    send_char(make_req(8'h5A, 0, 0, 20, 15, 8'hFF));
    send_char(make_req(8'h30, 1, 100, 100, 2, 8'h55));
    send_char(make_req(8'h39, 0, 0, 100, 2, 8'hAA));
    send_char(make_req(8'h2D, 0, 0, 100, 3, 8'h0F));
    send_char(make_req(8'h2E, 0, 0, 100, 3, 8'hF0));
    send_char(make_req(8'h20, 0, 0, 100, 4, 8'h11));
    send_char(make_req(8'h7F, 0, 0, 100, 2, 8'h22));
    send_char(make_req(8'hFF, 0, 0, 100, 2, 8'h33));
    send_char(make_req(8'h80, 1, 40, 60, 1, 8'h44));
    // zero scale: nothing drawn, cursor stays put
    send_char(make_req(8'h42, 1, 50, 30, 0, 8'h66));
    send_char(make_req(8'h43, 0, 0, 30, 1, 8'h77));
    // pen at the corners of the coordinate range
    send_char(make_req(8'h57, 1, -2048, -2048, 15, 8'h88));
    send_char(make_req(8'h4D, 1, 2047, 2047, 15, 8'h99));
    // partial clipping on every edge
    send_char(make_req(8'h48, 1, -3, -5, 4, 8'hBB));
    send_char(make_req(8'h4D, 1, 316, 283, 3, 8'hCC));
    send_char(make_req(8'h38, 1, 0, 0, 1, 8'h81));
    send_char(make_req(8'h51, 1, 314, 281, 1, 8'h7E));
    send_char(make_req(8'h00, 1, -1, 0, 1, 8'hDD));
  endtask

  // Long string at full scale: the cursor walks in from far left of the
  // frame and the last letters come into view
  task automatic run_long_string();
    logic [7:0] code;
    send_char(make_req(8'h20, 1, -2048, 10, 15, 8'h01));
    for (int k = 1; k <= 24; k++) begin
      code = (k >= 18) ? 8'(8'h41 + $urandom_range(25)) : 8'h20;
      send_char(make_req(code, 0, 0, $urandom_range(200), 15, 8'($urandom_range(255))));
    end
  endtask

  initial begin : stimulus
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= RegFrameWidth;
    cfg_wdata_i   <= '0;
    rst_ni        <= 1'b0;
    steady_flow   = 1'b0;
    hold_req      = 1'b0;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_long_string();

    // receiver holds off while characters keep coming
    drain_blitter();
    hold_req = 1'b1;
    run_phase(1024, 1024, 60);
    run_phase(2047, 2000, 30);
    run_phase(1, 1, 12);
    run_phase(0, 0, 10);
    run_phase(0, 700, 8);
    steady_flow = 1'b1;
    run_phase(320, 288, 60);
    run_phase(40, 30, 40);
    steady_flow = 1'b0;
    run_phase($urandom_range(1, 1024), $urandom_range(1, 1024), 46);
    drain_blitter();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("glyph_text_rect_blitter: match");
    end else begin
      $display("glyph_text_rect_blitter: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/gtrb_pkg.sv
sv/gtrb_clip.sv
sv/gtrb_ctrl.sv
sv/glyph_text_rect_blitter.sv
tb/gtrb_tb_pkg.sv
tb/tb_top.sv
